>>> src/tccw_pkg.sv
package tccw_pkg;

   // Screen geometry and tab spacing.
   localparam int ROW_STRIDE = 80;
   localparam int TAB_WIDTH  = 8;

   localparam int COL_WIDTH   = 7;
   localparam int ROW_WIDTH   = 6;
   localparam int INDEX_WIDTH = 13;
   localparam int COL_MAX     = 127;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FOREGROUND = 3'd0;
   localparam logic [2:0] CSR_BACKGROUND = 3'd1;
   localparam logic [2:0] CSR_RIGHT      = 3'd2;
   localparam logic [2:0] CSR_ROWS       = 3'd3;
   localparam logic [2:0] CSR_MARGIN     = 3'd4;

   // Request modes.
   localparam logic MODE_PUT_CHAR = 1'b0;
   localparam logic MODE_SET_POS  = 1'b1;

   // Control characters.
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_RETURN    = 8'd13;

   typedef logic [COL_WIDTH-1:0]   col_type;
   typedef logic [ROW_WIDTH-1:0]   row_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef col_type tab_table_type [2**COL_WIDTH];

   // Next tab stop for every column, saturated at the last column.
   function automatic tab_table_type build_tab_table();
      tab_table_type tbl;
      int            stop;
      for (int i = 0; i < 2**COL_WIDTH; i++) begin
         stop = i + TAB_WIDTH - (i % TAB_WIDTH);
         if (stop > COL_MAX) begin
            stop = COL_MAX;
         end
         tbl[i] = COL_WIDTH'(stop);
      end
      return tbl;
   endfunction

   localparam tab_table_type TAB_STOP_TABLE = build_tab_table();

   // Cell index of a row and column, kept to the index width.
   function automatic index_type cell_of(row_type row, col_type col);
      logic [INDEX_WIDTH:0] prod;
      logic [INDEX_WIDTH:0] sum;
      prod = (INDEX_WIDTH+1)'(row) * (INDEX_WIDTH+1)'(ROW_STRIDE);
      sum  = prod + (INDEX_WIDTH+1)'(col);
      return sum[INDEX_WIDTH-1:0];
   endfunction

endpackage

>>> src/text_console_cursor_writer_core.sv
// Cursor engine of a text console.
// Requests arrive on the req_ stream: req_tuser selects between putting one
// character (0) and placing the cursor directly (1). Each accepted transaction
// produces exactly one response on the rsp_ stream: an optional screen cell
// write (rsp_tuser high) with its cell index, character and attribute, plus
// the new hardware cursor cell index.
// The csr_ port writes the colors, the right limit, the row limit and the
// left margin; it is always ready and should be used only while idle.
// The response is registered and appears in the cycle after acceptance.
// One transaction is accepted per cycle unless the receiver stalls; the cursor
// registers update at acceptance, so the next request sees the new position at once.
// When the receiver stalls, the response stays in the output register and a
// new request is taken only in a cycle where that register is being emptied.
// Reset puts the cursor at row 0, column 0, restores the default
// configuration and empties the output register.
module text_console_cursor_writer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], new_col[14:8], new_row[20:15]
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // cell_index[12:0], cell_char[20:13],
                                    // cell_attr[28:21], cursor_pos[41:29]
   output logic        rsp_tuser,   // cell_write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import tccw_pkg::*;

   logic [3:0] fg_ff, fg_in;
   logic [3:0] bg_ff, bg_in;
   col_type    right_ff, right_in;
   row_type    rows_ff, rows_in;
   col_type    margin_ff, margin_in;

   col_type    col_ff, col_in;
   row_type    row_ff, row_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       wr_ff;
   index_type  widx_ff;
   logic [7:0] wchar_ff;
   logic [7:0] wattr_ff;
   index_type  pos_ff;

   logic       req_accept;
   logic       csr_accept;
   logic       mode;
   logic [7:0] char_code;
   col_type    new_col;
   row_type    new_row;

   logic       wr;
   col_type    wcol;
   logic [7:0] wchar;
   col_type    col_work;
   logic [ROW_WIDTH:0] row_work;
   logic [COL_WIDTH:0] col_plus;
   logic       step_back;

   assign mode      = req_tuser;
   assign char_code = req_tdata[7:0];
   assign new_col   = req_tdata[14:8];
   assign new_row   = req_tdata[20:15];

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid & csr_ready;
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;

   always_comb begin
      fg_in     = fg_ff;
      bg_in     = bg_ff;
      right_in  = right_ff;
      rows_in   = rows_ff;
      margin_in = margin_ff;
      if (csr_accept) begin
         case (csr_index)
            CSR_FOREGROUND: fg_in     = csr_data[3:0];
            CSR_BACKGROUND: bg_in     = csr_data[3:0];
            CSR_RIGHT:      right_in  = csr_data;
            CSR_ROWS:       rows_in   = csr_data[5:0];
            CSR_MARGIN:     margin_in = csr_data;
            default: ;
         endcase
      end
   end

   // Cursor movement for one character, or direct placement in set-position mode.
   always_comb begin
      wr       = 1'b0;
      wcol     = col_ff;
      wchar    = 8'd0;
      col_work = col_ff;
      row_work = {1'b0, row_ff};
      col_plus = {1'b0, col_ff} + 1'b1;
      case (char_code)
         CHAR_NEWLINE: begin
            col_work = margin_ff;
            row_work = {1'b0, row_ff} + 1'b1;
         end
         CHAR_BACKSPACE: begin
            if (col_ff != '0) begin
               col_work = col_ff - 1'b1;
               wcol     = col_ff - 1'b1;
               wr       = 1'b1;
            end
         end
         CHAR_TAB: begin
            col_work = TAB_STOP_TABLE[col_ff];
         end
         CHAR_RETURN: begin
            col_work = margin_ff;
         end
         default: begin
            wr    = 1'b1;
            wchar = char_code;
            // A right limit of zero makes every printed character wrap.
            if (col_plus >= {1'b0, right_ff}) begin
               col_work = margin_ff;
               row_work = {1'b0, row_ff} + 1'b1;
            end else begin
               col_work = col_plus[COL_WIDTH-1:0];
            end
         end
      endcase

      step_back = row_work >= {1'b0, rows_ff};
      if (step_back) begin
         row_work = (row_work != '0) ? row_work - 1'b1 : row_work;
         col_work = (col_work != '0) ? col_work - 1'b1 : col_work;
      end

      if (mode == MODE_SET_POS) begin
         wr     = 1'b0;
         col_in = new_col;
         row_in = new_row;
      end else begin
         col_in = col_work;
         row_in = row_work[ROW_WIDTH-1:0];
      end
   end

   assign rsp_valid_in = req_accept | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff        <= 4'd7;
         bg_ff        <= 4'd0;
         right_ff     <= COL_WIDTH'(80);
         rows_ff      <= ROW_WIDTH'(25);
         margin_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         right_ff     <= right_in;
         rows_ff      <= rows_in;
         margin_ff    <= margin_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         wr_ff    <= wr;
         widx_ff  <= wr ? cell_of(row_ff, wcol) : '0;
         wchar_ff <= wr ? wchar : 8'd0;
         wattr_ff <= wr ? {bg_ff, fg_ff} : 8'd0;
         pos_ff   <= cell_of(row_in, col_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = wr_ff;
   assign rsp_tdata  = {6'd0, pos_ff, wattr_ff, wchar_ff, widx_ff};

`ifndef SYNTHESIS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_set_pos: assert property (@(posedge clock) disable iff (reset)
      (req_accept && mode == MODE_SET_POS) |=>
         (col_ff == $past(new_col) && row_ff == $past(new_row) && !wr_ff))
      else $error("set cursor did not place the cursor");

   a_no_write_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !wr_ff) |-> (widx_ff == '0 && wchar_ff == 8'd0 && wattr_ff == 8'd0))
      else $error("cell fields not cleared without a write");
`endif

endmodule
